### rtl/b32e_pkg.sv
`timescale 1ns / 1ps

package b32e_pkg;

  // Bytes in one base32 group, bits per group and bits per character.
  localparam int unsigned GroupBytes = 5;
  localparam int unsigned GroupBits  = 8 * GroupBytes;
  localparam int unsigned SymBits    = 5;

  // ASCII codes used by the alphabets and padding.
  localparam logic [6:0] CharPad   = 7'h3D;
  localparam logic [6:0] CharUpA   = 7'h41;
  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharTwo   = 7'h32;
  localparam logic [6:0] LettersStd = 7'd26;
  localparam logic [6:0] DigitsHex  = 7'd10;

  // One complete group handed from the packer to the serializer.
  typedef struct packed {
    logic [GroupBits-1:0] bits;    // first byte in the top bits
    logic [3:0]           nchars;  // number of data characters, rest is padding
  } grp_t;

  // Data characters for a group that holds count+1 bytes.
  function automatic logic [3:0] data_chars(input logic [2:0] count);
    logic [3:0] n;
    begin
      unique case (count)
        3'd0:    n = 4'd2;
        3'd1:    n = 4'd4;
        3'd2:    n = 4'd5;
        3'd3:    n = 4'd7;
        default: n = 4'd8;
      endcase
      return n;
    end
  endfunction

  // Map a 5-bit symbol to ASCII through the standard or extended-hex alphabet.
  function automatic logic [6:0] map_sym(input logic [4:0] v, input logic hex);
    logic [6:0] v7;
    logic [6:0] c;
    begin
      v7 = {2'b00, v};
      if (hex) begin
        if (v7 < DigitsHex) c = CharZero + v7;
        else                c = CharUpA + (v7 - DigitsHex);
      end else begin
        if (v7 < LettersStd) c = CharUpA + v7;
        else                 c = CharTwo + (v7 - LettersStd);
      end
      return c;
    end
  endfunction

endpackage

### rtl/b32e_packer.sv
`timescale 1ns / 1ps

module b32e_packer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_data_i,
  output logic            grp_valid_o,
  output b32e_pkg::grp_t  grp_o,
  input  logic            grp_take_i
);
  import b32e_pkg::*;

  logic [7:0] held_q [4];
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] cnt_sat;
  logic       grp_valid_q, grp_valid_d;
  grp_t       grp_q, grp_d;
  logic       accept;
  logic       complete;
  logic [GroupBits-1:0] bits;

  // A word is taken whenever the group buffer is free or being drained.
  assign in_ready_o = !grp_valid_q || grp_take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_sat    = (cnt_q > 3'd4) ? 3'd4 : cnt_q;
  assign complete   = (cnt_sat == 3'd4) || end_of_data_i;

  // Assemble the group: held bytes, then the new byte, then zeros.
  always_comb begin
    for (int k = 0; k < GroupBytes; k++) begin
      if (k < 4 && 3'(k) < cnt_sat) begin
        bits[GroupBits-1-8*k -: 8] = held_q[2'(k)];
      end else if (3'(k) == cnt_sat) begin
        bits[GroupBits-1-8*k -: 8] = data_byte_i;
      end else begin
        bits[GroupBits-1-8*k -: 8] = 8'h00;
      end
    end
  end

  // Next state of the count and the group buffer.
  always_comb begin
    cnt_d       = cnt_q;
    grp_valid_d = grp_valid_q && !grp_take_i;
    grp_d       = grp_q;
    if (accept) begin
      if (complete) begin
        cnt_d        = 3'd0;
        grp_valid_d  = 1'b1;
        grp_d.bits   = bits;
        grp_d.nchars = data_chars(cnt_sat);
      end else begin
        cnt_d = cnt_sat + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 3'd0;
      grp_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      grp_valid_q <= grp_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    if (accept && !complete) begin
      held_q[cnt_sat[1:0]] <= data_byte_i;
    end
  end

  assign grp_valid_o = grp_valid_q;
  assign grp_o       = grp_q;

endmodule

### rtl/b32e_serializer.sv
`timescale 1ns / 1ps

module b32e_serializer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            hex_alphabet_i,
  input  logic            grp_valid_i,
  input  b32e_pkg::grp_t  grp_i,
  output logic            grp_take_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [6:0]      text_char_o,
  output logic            group_end_o
);
  import b32e_pkg::*;

  logic                 active_q;
  logic [2:0]           idx_q;
  logic [GroupBits-1:0] sh_q;
  logic [3:0]           nch_q;
  logic                 out_valid_q;
  logic [6:0]           char_q;
  logic                 end_q;
  logic                 out_free;
  logic                 emit;
  logic                 last;
  logic [6:0]           char_d;

  // The output register takes a new word when empty or being read.
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = active_q && out_free;
  assign last       = (idx_q == 3'd7);
  assign grp_take_o = grp_valid_i && (!active_q || (emit && last));

  // Current symbol sits in the top five bits of the shift register.
  assign char_d = ({1'b0, idx_q} < nch_q)
                ? map_sym(sh_q[GroupBits-1 -: SymBits], hex_alphabet_i)
                : CharPad;

  // Control: group active flag, character index and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (grp_take_o) begin
        active_q <= 1'b1;
        idx_q    <= 3'd0;
      end else if (emit) begin
        idx_q <= idx_q + 3'd1;
        if (last) begin
          active_q <= 1'b0;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: group bits, character count and the output word.
  always_ff @(posedge clk_i) begin
    if (grp_take_o) begin
      sh_q  <= grp_i.bits;
      nch_q <= grp_i.nchars;
    end else if (emit) begin
      sh_q <= {sh_q[GroupBits-SymBits-1:0], {SymBits{1'b0}}};
    end
    if (emit) begin
      char_q <= char_d;
      end_q  <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign group_end_o = end_q;

endmodule

### rtl/base32_encoder.sv
`timescale 1ns / 1ps
// Base32 encoder (RFC 4648), streaming.
// Input channel: one raw byte per word (data_byte_i) with end_of_data_i
// marking the final byte of a message; in_valid_i / in_ready_o handshake.
// Output channel: one ASCII character per word (text_char_o), group_end_o
// high on the eighth character of each group; out_valid_o / out_ready_i.
// Up to four bytes are held; the fifth byte, or a byte marked last, closes
// a group that leaves as eight characters, short groups padded with '='.
// cfg_we_i writes cfg_wdata_i into the alphabet select (0 standard A-Z2-7,
// 1 extended hex 0-9A-V); write it only while the block is idle.
// Data path: the byte that closes a group enters the packer's group buffer,
// then the serializer's shift register, then the output register.
// Throughput: the output port moves one character per cycle while
// out_ready_i is high; byte words are taken in every cycle while the single
// group buffer is free.
// Reset clears the held byte count, the pending group, the output valid
// flag and selects the standard alphabet. When the receiver stalls, the
// output word holds; the group buffer then fills and in_ready_o drops.
module base32_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] text_char_o,
  output logic       group_end_o
);
  import b32e_pkg::*;

  logic hex_q;
  logic grp_valid;
  logic grp_take;
  grp_t grp;

  // Alphabet select register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hex_q <= 1'b0;
    end else if (cfg_we_i) begin
      hex_q <= cfg_wdata_i;
    end
  end

  b32e_packer u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .end_of_data_i (end_of_data_i),
    .grp_valid_o   (grp_valid),
    .grp_o         (grp),
    .grp_take_i    (grp_take)
  );

  b32e_serializer u_serializer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .hex_alphabet_i (hex_q),
    .grp_valid_i    (grp_valid),
    .grp_i          (grp),
    .grp_take_o     (grp_take),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .text_char_o    (text_char_o),
    .group_end_o    (group_end_o)
  );

endmodule

### rtl/b32e_checker.sv
`timescale 1ns / 1ps

module b32e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] text_char_o,
  input logic       group_end_o
);

  // A stalled output word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(text_char_o)
      && $stable(group_end_o))
    else $error("stalled output word changed");

  // Every character is a digit, an upper-case letter or padding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (text_char_o == 7'h3D)
      || (text_char_o >= 7'h30 && text_char_o <= 7'h39)
      || (text_char_o >= 7'h41 && text_char_o <= 7'h5A))
    else $error("character outside the base32 alphabets");

  // The first character of a group is never padding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && group_end_o ##1 out_valid_o
      |-> text_char_o != 7'h3D)
    else $error("group starts with padding");

  // Once padding starts it runs to the end of the group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !group_end_o && text_char_o == 7'h3D
      ##1 out_valid_o |-> text_char_o == 7'h3D)
    else $error("data character after padding");

endmodule

bind base32_encoder b32e_checker u_b32e_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .text_char_o (text_char_o),
  .group_end_o (group_end_o)
);
